// ----- sv/median_filter_5x5_rgb_macros.svh -----
// Assertion macros for the 5x5 RGB median filter.
`ifndef MEDIAN_FILTER_5X5_RGB_MACROS_SVH
`define MEDIAN_FILTER_5X5_RGB_MACROS_SVH
`ifndef SYNTHESIS
`define MF5_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mf5 check failed");
`define MF5_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mf5 check failed");
`else
`define MF5_ASSERT_IMP(lbl, pre, post)
`define MF5_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// ----- sv/mf5_pkg.sv -----
// Shared types and constants of the 5x5 RGB median filter.
package mf5_pkg;

    localparam int WIN            = 5;
    localparam int WIN_CELLS      = 25;
    localparam int MEDIAN_RANK    = 12;
    localparam int LINES          = 4;
    localparam int CH_W           = 8;
    localparam int PIX_W          = 24;
    localparam int STRIDE_W       = 12;
    localparam int WIDTH_W        = 11;
    localparam int HEIGHT_W       = 12;
    localparam int CFG_W          = 12;
    localparam int MIN_STRIDE     = 5;
    localparam int MAX_OUT_HEIGHT = 4092;
    localparam int CNT_W          = 5;

    typedef enum logic [1:0] {
        CFG_STRIDE = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2,
        CFG_NONE   = 2'd3
    } cfg_index_t;

    typedef logic [CH_W-1:0] chan_t;
    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic produced;
        logic row_end;
        logic frame_end;
    } mf5_meta_t;

endpackage

// ----- sv/mf5_lane.sv -----
// One colour lane: exact rank-13 selection over 25 window values in three stages.
module mf5_lane (
    input  logic             clk,
    input  logic             adv,
    input  mf5_pkg::chan_t   vals [mf5_pkg::WIN_CELLS],
    output mf5_pkg::chan_t   median
);
    import mf5_pkg::*;

    logic [WIN_CELLS-1:0] lt_reg [WIN_CELLS];
    logic [WIN_CELLS-1:0] gt_reg [WIN_CELLS];
    chan_t                va_reg [WIN_CELLS];
    logic [CNT_W-1:0]     less_reg [WIN_CELLS];
    logic [CNT_W-1:0]     more_reg [WIN_CELLS];
    chan_t                vb_reg [WIN_CELLS];
    chan_t                median_reg;
    chan_t                median_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < WIN_CELLS; i++)
            begin
                va_reg[i] <= vals[i];
                for (int j = 0; j < WIN_CELLS; j++)
                begin
                    lt_reg[i][j] <= vals[j] < vals[i];
                    gt_reg[i][j] <= vals[j] > vals[i];
                end
            end
            for (int i = 0; i < WIN_CELLS; i++)
            begin
                less_reg[i] <= CNT_W'($countones(lt_reg[i]));
                more_reg[i] <= CNT_W'($countones(gt_reg[i]));
                vb_reg[i]   <= va_reg[i];
            end
            median_reg <= median_next;
        end
    end

    always_comb
    begin
        median_next = '0;
        for (int i = 0; i < WIN_CELLS; i++)
        begin
            if (less_reg[i] <= CNT_W'(MEDIAN_RANK) && more_reg[i] <= CNT_W'(MEDIAN_RANK))
            begin
                median_next = median_next | vb_reg[i];
            end
        end
    end

    assign median = median_reg;

endmodule

// ----- sv/mf5_window.sv -----
// Line stores, 5x5 window and raster counters of the median filter.
module mf5_window #(
    parameter int MAX_ROW_PIXELS = 2048
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    accept,
    input  mf5_pkg::pix_t           pix,
    input  logic                    cfg_write_en,
    input  logic [1:0]              cfg_index,
    input  logic [mf5_pkg::CFG_W-1:0] cfg_data,
    output mf5_pkg::pix_t           win [mf5_pkg::WIN_CELLS],
    output mf5_pkg::mf5_meta_t      meta
);
    import mf5_pkg::*;

    localparam int AW = $clog2(MAX_ROW_PIXELS);
    localparam int SW = (AW + 1 > STRIDE_W) ? AW + 1 : STRIDE_W;

    logic [STRIDE_W-1:0] stride_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [AW-1:0]       col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;

    logic [LINES*PIX_W-1:0] mem [MAX_ROW_PIXELS];
    logic [LINES*PIX_W-1:0] rd_reg;
    logic [LINES*PIX_W-1:0] wr_data;
    pix_t                   pix_reg;
    logic [AW-1:0]          addr_reg;
    logic                   s1_valid_reg;
    mf5_meta_t              s1_meta_reg, s1_meta_next;
    mf5_meta_t              meta_reg;
    pix_t                   win_reg [WIN][WIN];
    pix_t                   column [WIN];

    logic [SW-1:0]       s_raw, s_eff, w_raw, w_lim, w_eff, c_ext;
    logic [HEIGHT_W-1:0] h_eff;

    always_comb
    begin
        s_raw = SW'(stride_reg);
        if (s_raw < SW'(MIN_STRIDE))
            s_eff = SW'(MIN_STRIDE);
        else if (s_raw > SW'(MAX_ROW_PIXELS))
            s_eff = SW'(MAX_ROW_PIXELS);
        else
            s_eff = s_raw;
        w_lim = s_eff - SW'(WIN - 1);
        w_raw = SW'(width_reg);
        if (w_raw < SW'(1))
            w_eff = SW'(1);
        else if (w_raw > w_lim)
            w_eff = w_lim;
        else
            w_eff = w_raw;
        if (height_reg < HEIGHT_W'(1))
            h_eff = HEIGHT_W'(1);
        else if (height_reg > HEIGHT_W'(MAX_OUT_HEIGHT))
            h_eff = HEIGHT_W'(MAX_OUT_HEIGHT);
        else
            h_eff = height_reg;
        c_ext = SW'(col_reg);

        s1_meta_next.produced  = (row_reg >= HEIGHT_W'(WIN - 1)) && (c_ext >= SW'(WIN - 1))
                               && ((c_ext - SW'(WIN - 1)) < w_eff)
                               && ((row_reg - HEIGHT_W'(WIN - 1)) < h_eff);
        s1_meta_next.row_end   = c_ext == w_eff + SW'(WIN - 2);
        s1_meta_next.frame_end = s1_meta_next.row_end
                               && (row_reg == h_eff + HEIGHT_W'(WIN - 2));

        if (c_ext + SW'(1) >= s_eff)
        begin
            col_next = '0;
            if (row_reg >= h_eff + HEIGHT_W'(WIN - 2))
                row_next = '0;
            else
                row_next = row_reg + HEIGHT_W'(1);
        end
        else
        begin
            col_next = col_reg + AW'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= STRIDE_W'(2048);
            width_reg  <= WIDTH_W'(2044);
            height_reg <= HEIGHT_W'(4092);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_STRIDE: stride_reg <= cfg_data;
                CFG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            meta_reg     <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            meta_reg     <= s1_valid_reg ? s1_meta_reg : '0;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg      <= mem[col_reg];
            addr_reg    <= col_reg;
            pix_reg     <= pix;
            s1_meta_reg <= s1_meta_next;
        end
        if (adv && s1_valid_reg)
            mem[addr_reg] <= wr_data;
    end

    always_comb
    begin
        for (int i = 0; i < LINES; i++)
            column[i] = rd_reg[i*PIX_W +: PIX_W];
        column[LINES] = pix_reg;
        for (int i = 0; i < LINES; i++)
            wr_data[i*PIX_W +: PIX_W] = column[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN; i++)
                for (int j = 0; j < WIN; j++)
                    win_reg[i][j] <= '0;
        end
        else if (adv && s1_valid_reg)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                for (int j = 0; j < WIN - 1; j++)
                    win_reg[i][j] <= win_reg[i][j+1];
                win_reg[i][WIN-1] <= column[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < WIN; i++)
            for (int j = 0; j < WIN; j++)
                win[i*WIN + j] = win_reg[i][j];
    end

    assign meta = meta_reg;

endmodule

// ----- sv/median_filter_5x5_rgb.sv -----
// Top level of the 5x5 RGB median filter.
// Usage:
//   Source pixels enter on in_valid/in_ready, one beat per pixel in raster
//   order over the padded frame; filtered pixels leave on out_valid/out_ready
//   with row_end and frame_end marking the last pixel of a row and frame.
//   Registers stride, width and height are written on cfg_write_en with
//   cfg_index and cfg_data while the block is idle.
//   A result leaves through the input registers, the window register and the
//   three lane stages after the source pixel completing its window is accepted.
//   Throughput: one pixel per cycle unless out_ready stalls; the line store is
//   one wide memory read at accept and written back as the pipeline advances;
//   three colour lanes select medians in a three-stage compare/count pipeline.
//   Reset clears counters, window and pipeline flags, and sets the registers to
//   2048, 2044 and 4092; line store contents stay undefined until written.
//   A stalled output holds its beat and freezes the whole pipeline, so
//   in_ready falls while out_valid waits on out_ready.
module median_filter_5x5_rgb #(
    parameter int MAX_ROW_PIXELS = 2048
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  mf5_pkg::chan_t             red_in,
    input  mf5_pkg::chan_t             green_in,
    input  mf5_pkg::chan_t             blue_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output mf5_pkg::chan_t             red_out,
    output mf5_pkg::chan_t             green_out,
    output mf5_pkg::chan_t             blue_out,
    output logic                       row_end,
    output logic                       frame_end,
    input  logic                       cfg_write_en,
    input  logic [1:0]                 cfg_index,
    input  logic [mf5_pkg::CFG_W-1:0]  cfg_data
);
    import mf5_pkg::*;
`include "median_filter_5x5_rgb_macros.svh"

    logic      adv;
    logic      accept;
    pix_t      win [WIN_CELLS];
    chan_t     r_vals [WIN_CELLS];
    chan_t     g_vals [WIN_CELLS];
    chan_t     b_vals [WIN_CELLS];
    mf5_meta_t meta;
    mf5_meta_t ma_reg, mb_reg, mo_reg;

    assign adv      = !mo_reg.produced || out_ready;
    assign in_ready = adv;
    assign accept   = in_valid && adv;

    mf5_window #(.MAX_ROW_PIXELS(MAX_ROW_PIXELS)) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .accept       (accept),
        .pix          ({blue_in, green_in, red_in}),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .win          (win),
        .meta         (meta)
    );

    always_comb
    begin
        for (int i = 0; i < WIN_CELLS; i++)
        begin
            r_vals[i] = win[i][7:0];
            g_vals[i] = win[i][15:8];
            b_vals[i] = win[i][23:16];
        end
    end

    mf5_lane u_lane_r (.clk(clk), .adv(adv), .vals(r_vals), .median(red_out));
    mf5_lane u_lane_g (.clk(clk), .adv(adv), .vals(g_vals), .median(green_out));
    mf5_lane u_lane_b (.clk(clk), .adv(adv), .vals(b_vals), .median(blue_out));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ma_reg <= '0;
            mb_reg <= '0;
            mo_reg <= '0;
        end
        else if (adv)
        begin
            ma_reg <= meta;
            mb_reg <= ma_reg;
            mo_reg <= mb_reg;
        end
    end

    assign out_valid = mo_reg.produced;
    assign row_end   = mo_reg.row_end;
    assign frame_end = mo_reg.frame_end;

    `MF5_ASSERT_IMP(a_frame_end_on_row_end, out_valid && frame_end, row_end)
    `MF5_ASSERT_IMP(a_stall_blocks_input, out_valid && !out_ready, !in_ready)
    `MF5_ASSERT_NXT(a_stall_holds_median, out_valid && !out_ready,
                    $stable(red_out) && $stable(green_out) && $stable(blue_out))

endmodule

// ----- sim/tb_median_filter_5x5_rgb.sv -----
// Self-checking testbench of the 5x5 RGB median filter: whole frames under many settings.
module tb_median_filter_5x5_rgb;
    timeunit 1ns;
    timeprecision 1ps;
    import mf5_pkg::*;

    localparam int ROW_PIXELS = 2048;
    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  row_end;
        logic  frame_end;
    } filt_pix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    chan_t red_in = '0;
    chan_t green_in = '0;
    chan_t blue_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;
    logic row_end;
    logic frame_end;
    logic cfg_write_en = 1'b0;
    logic [1:0] cfg_index = CFG_NONE;
    logic [CFG_W-1:0] cfg_data = '0;

    pix_t pixel_q[$];
    filt_pix_t filtered_q[$];

    logic [STRIDE_W-1:0] stride_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    pix_t line_mem[LINES][ROW_PIXELS];
    pix_t win_px[WIN][WIN];
    int unsigned col_cnt;
    int unsigned row_cnt;

    int send_gap = 0;
    int rx_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit calm = 1'b0;
    int unsigned pixels_in = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned frames_sent = 0;
    int unsigned idle_cycles = 0;

    median_filter_5x5_rgb u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
        .row_end(row_end), .frame_end(frame_end),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic chan_t median_of(int shift);
        chan_t v[WIN_CELLS];
        chan_t x;
        int n;
        int j;
        n = 0;
        for (int i = 0; i < WIN; i++)
            for (int k = 0; k < WIN; k++)
                v[n++] = win_px[i][k][shift +: CH_W];
        for (int i = 1; i < WIN_CELLS; i++) begin
            x = v[i];
            j = i - 1;
            while (j >= 0 && v[j] > x) begin
                v[j + 1] = v[j];
                j--;
            end
            v[j + 1] = x;
        end
        return v[MEDIAN_RANK];
    endfunction

    task automatic filter_pixel(input pix_t p);
        int unsigned s;
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        pix_t column[WIN];
        filt_pix_t f;
        s = stride_reg;
        if (s < MIN_STRIDE) s = MIN_STRIDE;
        if (s > ROW_PIXELS) s = ROW_PIXELS;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > s - 4) w = s - 4;
        h = height_reg;
        if (h < 1) h = 1;
        if (h > MAX_OUT_HEIGHT) h = MAX_OUT_HEIGHT;
        c = col_cnt;
        r = row_cnt;
        for (int i = 0; i < LINES; i++) column[i] = line_mem[i][c];
        column[LINES] = p;
        for (int i = 0; i < LINES; i++) line_mem[i][c] = column[i + 1];
        for (int i = 0; i < WIN; i++) begin
            for (int k = 0; k < WIN - 1; k++) win_px[i][k] = win_px[i][k + 1];
            win_px[i][WIN - 1] = column[i];
        end
        if (r >= 4 && c >= 4 && c - 4 < w && r - 4 < h) begin
            f.red = median_of(0);
            f.green = median_of(8);
            f.blue = median_of(16);
            f.row_end = (c - 4 == w - 1);
            f.frame_end = f.row_end && (r - 4 == h - 1);
            filtered_q.push_back(f);
        end
        if (c + 1 >= s) begin
            col_cnt = 0;
            row_cnt = (r >= h + 3) ? 0 : ((r + 1) & 12'hFFF);
        end else begin
            col_cnt = c + 1;
        end
    endtask

    always @(posedge clk) begin : drv
        pix_t p;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                filter_pixel({blue_in, green_in, red_in});
                pixels_in++;
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    p = pixel_q.pop_front();
                    red_in <= p[7:0];
                    green_in <= p[15:8];
                    blue_in <= p[23:16];
                    in_valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : mon
        filt_pix_t f;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (filtered_q.size() == 0) begin
                    $display("%0t: unexpected beat r=%0d g=%0d b=%0d", $time,
                             red_out, green_out, blue_out);
                    mismatches++;
                end else begin
                    f = filtered_q.pop_front();
                    if (f.red !== red_out || f.green !== green_out || f.blue !== blue_out
                        || f.row_end !== row_end || f.frame_end !== frame_end) begin
                        $display("%0t: expected rgb %0d %0d %0d re %0b fe %0b", $time,
                                 f.red, f.green, f.blue, f.row_end, f.frame_end);
                        $display("%0t: actual   rgb %0d %0d %0d re %0b fe %0b", $time,
                                 red_out, green_out, blue_out, row_end, frame_end);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (!hold_done && results_seen >= 100) begin
                hold_done <= 1'b1;
                hold_left <= 400;
                out_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (out_valid && out_ready) rx_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no progress, pending %0d", $time, filtered_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        case (idx)
            CFG_STRIDE: stride_reg = value[STRIDE_W-1:0];
            CFG_WIDTH:  width_reg = value[WIDTH_W-1:0];
            CFG_HEIGHT: height_reg = value[HEIGHT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cfg_index <= CFG_NONE;
    endtask

    task automatic drain();
        while (pixel_q.size() > 0 || in_valid || filtered_q.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic chan_t pick_chan(int mode);
        case (mode)
            0: return chan_t'($urandom_range(0, 255));
            1: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            default: return chan_t'($urandom_range(120, 136));
        endcase
    endfunction

    task automatic run_frame(input int unsigned s, input int unsigned w,
                             input int unsigned h, input int mode);
        int unsigned es;
        int unsigned eh;
        drain();
        write_reg(CFG_STRIDE, s);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        es = (s < MIN_STRIDE) ? MIN_STRIDE : ((s > ROW_PIXELS) ? ROW_PIXELS : s);
        eh = (h < 1) ? 1 : ((h > MAX_OUT_HEIGHT) ? MAX_OUT_HEIGHT : h);
        calm = ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < es * (eh + 4); i++)
            pixel_q.push_back({pick_chan(mode), pick_chan(mode), pick_chan(mode)});
        frames_sent++;
    endtask

    initial begin
        int unsigned s;
        stride_reg = 2048;
        width_reg = 2044;
        height_reg = 4092;
        col_cnt = 0;
        row_cnt = 0;
        for (int i = 0; i < LINES; i++)
            for (int k = 0; k < ROW_PIXELS; k++) line_mem[i][k] = '0;
        for (int i = 0; i < WIN; i++)
            for (int k = 0; k < WIN; k++) win_px[i][k] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_STRIDE, 5);
        write_reg(CFG_WIDTH, 1);
        write_reg(CFG_HEIGHT, 1);
        for (int i = 0; i < 25; i++) begin
            case (i % 5)
                0: pixel_q.push_back(24'h000000);
                1: pixel_q.push_back(24'hFFFFFF);
                2: pixel_q.push_back({8'hAA, 8'h55, 8'hFF});
                3: pixel_q.push_back({8'h01, 8'h80, 8'h7F});
                default: pixel_q.push_back({8'hFE, 8'h00, 8'h01});
            endcase
        end
        frames_sent++;

        run_frame(8, 4, 3, 0);
        run_frame(3, 0, 0, 1);
        run_frame(20, 2047, 6, 2);
        run_frame(9, 9, 3, 1);
        while (pixels_in + pixel_q.size() < 700) begin
            s = $urandom_range(5, 24);
            run_frame(s, $urandom_range(0, s), $urandom_range(1, 8), $urandom_range(0, 2));
        end
        drain();
        if (filtered_q.size() != 0) mismatches++;

        $display("run: %0d pixels over %0d frames, %0d filtered pixels checked",
                 pixels_in, frames_sent, results_seen);
        $display("run: small strides with clamped width and height, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ----- median_filter_5x5_rgb.f -----
+incdir+sv
sv/mf5_pkg.sv
sv/mf5_lane.sv
sv/mf5_window.sv
sv/median_filter_5x5_rgb.sv
sim/tb_median_filter_5x5_rgb.sv
